@@ design/cdf_pkg.sv @@
// ----------------------------------------------------------------------------
// cdf_pkg
// Shared types and constants of the complex decimating FIR filter bank.
// ----------------------------------------------------------------------------
package cdf_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int TAP_W       = 18;
  localparam int PROD_W      = SAMPLE_W + TAP_W;
  localparam int CFG_W       = 6;
  localparam int FREQS_CFG_W = 3;
  localparam int GC_W        = 5;
  localparam int SCALE_SHIFT = 18;

  localparam logic [CFG_W-1:0]       DEC_RESET   = 6'd8;
  localparam logic [FREQS_CFG_W-1:0] FREQS_RESET = 3'd1;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [TAP_W-1:0]    tap_t;

  typedef enum logic [1:0] {
    CMD_PUSH  = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_t;

  typedef enum logic {
    REG_DECIMATION = 1'b0,
    REG_FREQS      = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic push;
    logic load;
    logic clear;
    logic issue;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic group_done;
    logic k_last;
    logic f_last;
    logic acc_ready;
    logic out_free;
  } dp_status_t;

endpackage

@@ design/cdf_in_if.sv @@
// ----------------------------------------------------------------------------
// cdf_in_if
// Input channel: command, sample and tap fields with valid/ready.
// ----------------------------------------------------------------------------
interface cdf_in_if;
  logic             valid;
  logic             ready;
  logic [1:0]       command;
  cdf_pkg::sample_t sample_re;
  cdf_pkg::sample_t sample_im;
  logic [1:0]       tap_freq;
  logic [5:0]       tap_index;
  cdf_pkg::tap_t    tap_re;
  cdf_pkg::tap_t    tap_im;

  modport source (output valid, command, sample_re, sample_im, tap_freq, tap_index,
                  tap_re, tap_im, input ready);
  modport sink (input valid, command, sample_re, sample_im, tap_freq, tap_index,
                tap_re, tap_im, output ready);
endinterface

@@ design/cdf_out_if.sv @@
// ----------------------------------------------------------------------------
// cdf_out_if
// Output channel: one filtered complex result per transaction.
// ----------------------------------------------------------------------------
interface cdf_out_if;
  logic             valid;
  logic             ready;
  logic [1:0]       freq_index;
  cdf_pkg::sample_t out_re;
  cdf_pkg::sample_t out_im;
  logic             last;

  modport source (output valid, freq_index, out_re, out_im, last, input ready);
  modport sink (input valid, freq_index, out_re, out_im, last, output ready);
endinterface

@@ design/cdf_ram.sv @@
// ----------------------------------------------------------------------------
// cdf_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module cdf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/cdf_ctrl.sv @@
// ----------------------------------------------------------------------------
// cdf_ctrl
// Sequencer: accepts transactions, runs the tap sweep per frequency, emits.
// ----------------------------------------------------------------------------
module cdf_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [1:0]          in_command,
  output logic                in_ready,
  input  cdf_pkg::dp_status_t status,
  output cdf_pkg::dp_cmd_t    cmd
);
  import cdf_pkg::*;

  state_t state;
  state_t state_next;
  cmd_t   code;
  logic   accept;

  assign code   = cmd_t'(in_command);
  assign accept = (state == ST_IDLE) && in_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && (code == CMD_PUSH) && status.group_done) begin
          state_next = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        if (status.k_last) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (status.acc_ready && status.out_free) begin
          state_next = status.f_last ? ST_IDLE : ST_ISSUE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    cmd       = '0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (accept) begin
          unique case (code)
            CMD_PUSH:  cmd.push  = 1'b1;
            CMD_LOAD:  cmd.load  = 1'b1;
            CMD_CLEAR: cmd.clear = 1'b1;
            default:   cmd       = '0;
          endcase
        end
      end
      ST_ISSUE: begin
        cmd.issue = 1'b1;
      end
      ST_FINISH: begin
        cmd.emit = status.acc_ready && status.out_free;
      end
      default: cmd = '0;
    endcase
  end

endmodule

@@ design/cdf_datapath.sv @@
// ----------------------------------------------------------------------------
// cdf_datapath
// Sample ring, tap store, complex MAC pipeline and output register.
// ----------------------------------------------------------------------------
module cdf_datapath #(
  parameter int MAX_TAPS  = 64,
  parameter int NUM_FREQS = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  cdf_pkg::reg_idx_t             cfg_index,
  input  logic [cdf_pkg::CFG_W-1:0]     cfg_data,
  input  cdf_pkg::dp_cmd_t              cmd,
  output cdf_pkg::dp_status_t           status,
  input  cdf_pkg::sample_t              sample_re,
  input  cdf_pkg::sample_t              sample_im,
  input  logic [1:0]                    tap_freq,
  input  logic [5:0]                    tap_index,
  input  cdf_pkg::tap_t                 tap_re,
  input  cdf_pkg::tap_t                 tap_im,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [1:0]                    freq_index,
  output cdf_pkg::sample_t              out_re,
  output cdf_pkg::sample_t              out_im,
  output logic                          out_last
);
  import cdf_pkg::*;

  localparam int POS_W = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int LEN_W = $clog2(MAX_TAPS + 1);
  localparam int F_W   = (NUM_FREQS > 1) ? $clog2(NUM_FREQS) : 1;
  localparam int NF_W  = $clog2(NUM_FREQS + 1);
  localparam int TDEP  = NUM_FREQS * MAX_TAPS;
  localparam int TA_W  = (TDEP > 1) ? $clog2(TDEP) : 1;
  localparam int HALF  = MAX_TAPS / 2;
  localparam int ACC_W = PROD_W + 2 + POS_W;
  localparam int ROUND = (1 << SCALE_SHIFT) - 1;

  logic [CFG_W-1:0]       dec_raw;
  logic [FREQS_CFG_W-1:0] nf_raw;
  logic [CFG_W-1:0]       dec_eff;
  logic [NF_W-1:0]        nf_eff;
  logic [LEN_W-1:0]       len;

  logic [POS_W-1:0] wp;
  logic [POS_W-1:0] p;
  logic [POS_W-1:0] p_inc;
  logic [GC_W-1:0]  gc;
  logic [GC_W-1:0]  gc_inc;
  logic             group_done;

  logic [MAX_TAPS-1:0] ring_vld;
  logic [POS_W-1:0]    raddr;
  logic [POS_W-1:0]    rd_ptr;
  logic [POS_W-1:0]    rd_next;
  logic [2*SAMPLE_W-1:0] ring_q;
  logic [2*TAP_W-1:0]    tap_q;
  logic                  vld_q;
  logic                  tap_we;
  logic [TA_W-1:0]       tap_waddr;
  logic [TA_W-1:0]       tap_raddr;

  logic [POS_W-1:0] k;
  logic [F_W-1:0]   f;
  logic             k_first;
  logic             k_last;
  logic             f_last;

  logic v1, first1, last1;
  logic v2, first2, last2;
  tap_t    tr, ti;
  sample_t sr, si;
  logic signed [PROD_W-1:0] p_rr, p_ii, p_ri, p_ir;
  logic signed [ACC_W-1:0]  term_re, term_im;
  logic signed [ACC_W-1:0]  acc_re, acc_im;
  logic                     acc_ready;
  logic                     out_free;

  function automatic sample_t scale_sat(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-1:0] b;
    b = a + (a[ACC_W-1] ? ACC_W'(ROUND) : '0);
    b = b >>> SCALE_SHIFT;
    if (b > 32767) begin
      b = ACC_W'(32767);
    end else if (b < -32768) begin
      b = -ACC_W'(32768);
    end
    return SAMPLE_W'(b);
  endfunction

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      dec_raw <= DEC_RESET;
      nf_raw  <= FREQS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DECIMATION: dec_raw <= cfg_data;
        REG_FREQS:      nf_raw  <= cfg_data[FREQS_CFG_W-1:0];
      endcase
    end
  end

  always_comb begin
    if (dec_raw == '0) begin
      dec_eff = CFG_W'(1);
    end else if (32'(dec_raw) > HALF) begin
      dec_eff = CFG_W'(HALF);
    end else begin
      dec_eff = dec_raw;
    end
    if (nf_raw == '0) begin
      nf_eff = NF_W'(1);
    end else if (32'(nf_raw) > NUM_FREQS) begin
      nf_eff = NF_W'(NUM_FREQS);
    end else begin
      nf_eff = NF_W'(nf_raw);
    end
  end

  assign len = LEN_W'(2 * 32'(dec_eff));

  // write position and group count
  assign p          = (32'(wp) >= 32'(len)) ? '0 : wp;
  assign p_inc      = (32'(p) + 1 == 32'(len)) ? '0 : POS_W'(32'(p) + 1);
  assign gc_inc     = gc + GC_W'(1);
  assign group_done = (gc_inc == '0) || (32'(gc_inc) >= 32'(dec_eff));

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      gc <= '0;
    end else if (cmd.push) begin
      wp <= p_inc;
      gc <= group_done ? '0 : gc_inc;
    end
  end

  // ring entries read as zero until written after reset or clear
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      ring_vld <= '0;
    end else if (cmd.push) begin
      ring_vld[p] <= 1'b1;
    end
  end

  // tap sweep counters
  assign k_first = (k == '0);
  assign k_last  = (32'(k) + 1 == 32'(len));
  assign f_last  = (32'(f) + 1 == 32'(nf_eff));

  always_ff @(posedge clk) begin
    if (rst) begin
      k <= '0;
      f <= '0;
    end else begin
      if (cmd.issue) begin
        k <= k_last ? '0 : k + POS_W'(1);
      end
      if (cmd.emit) begin
        f <= f_last ? '0 : f + F_W'(1);
      end
    end
  end

  assign raddr   = k_first ? wp : rd_ptr;
  assign rd_next = (32'(raddr) + 1 == 32'(len)) ? '0 : POS_W'(32'(raddr) + 1);

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      rd_ptr <= rd_next;
    end
    vld_q <= ring_vld[raddr];
  end

  assign tap_we    = cmd.load && (32'(tap_freq) < NUM_FREQS) && (32'(tap_index) < MAX_TAPS);
  assign tap_waddr = TA_W'(32'(tap_freq) * MAX_TAPS + 32'(tap_index));
  assign tap_raddr = TA_W'(32'(f) * MAX_TAPS + 32'(k));

  cdf_ram #(
    .WIDTH (2 * SAMPLE_W),
    .DEPTH (MAX_TAPS)
  ) u_ring (
    .clk   (clk),
    .we    (cmd.push),
    .waddr (p),
    .wdata ({sample_re, sample_im}),
    .raddr (raddr),
    .rdata (ring_q)
  );

  cdf_ram #(
    .WIDTH (2 * TAP_W),
    .DEPTH (TDEP)
  ) u_taps (
    .clk   (clk),
    .we    (tap_we),
    .waddr (tap_waddr),
    .wdata ({tap_re, tap_im}),
    .raddr (tap_raddr),
    .rdata (tap_q)
  );

  // read stage flags
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= cmd.issue;
    end
    first1 <= k_first;
    last1  <= k_last;
  end

  // product stage
  assign tr = $signed(tap_q[2*TAP_W-1:TAP_W]);
  assign ti = $signed(tap_q[TAP_W-1:0]);
  assign sr = vld_q ? $signed(ring_q[2*SAMPLE_W-1:SAMPLE_W]) : '0;
  assign si = vld_q ? $signed(ring_q[SAMPLE_W-1:0]) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    first2 <= first1;
    last2  <= last1;
    p_rr   <= tr * sr;
    p_ii   <= ti * si;
    p_ri   <= tr * si;
    p_ir   <= ti * sr;
  end

  // accumulate stage
  assign term_re = ACC_W'(p_rr) - ACC_W'(p_ii);
  assign term_im = ACC_W'(p_ri) + ACC_W'(p_ir);

  always_ff @(posedge clk) begin
    if (v2) begin
      acc_re <= first2 ? term_re : acc_re + term_re;
      acc_im <= first2 ? term_im : acc_im + term_im;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_ready <= 1'b0;
    end else if (v2 && last2) begin
      acc_ready <= 1'b1;
    end else if (cmd.emit) begin
      acc_ready <= 1'b0;
    end
  end

  // output register
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      freq_index <= 2'(f);
      out_re     <= scale_sat(acc_re);
      out_im     <= scale_sat(acc_im);
      out_last   <= f_last;
    end
  end

  assign status.group_done = group_done;
  assign status.k_last     = k_last;
  assign status.f_last     = f_last;
  assign status.acc_ready  = acc_ready;
  assign status.out_free   = out_free;

  a_emit_needs_sum: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> acc_ready)
    else $error("result emitted before its sum is complete");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (v2 && first2) |-> !acc_ready)
    else $error("new sum starts over an unsent result");

  a_quiet_sweep: assert property (@(posedge clk) disable iff (rst)
    cmd.issue |-> !(cmd.push || cmd.load || cmd.clear))
    else $error("transaction taken during a tap sweep");

  a_freq_wrap: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && f_last) |=> (f == '0))
    else $error("frequency counter not back at zero after the group");

endmodule

@@ design/complex_decimating_fir.sv @@
// ----------------------------------------------------------------------------
// complex_decimating_fir
// Load, clear and non-final push transactions are taken in the idle state.
// A group-closing push starts a tap sweep for each frequency in use, one
// complex MAC per cycle through the ring and tap RAM read ports; a stalled
// output adds its wait before each result.
// Reset clears control, position and count; ring entries read as zero through
// per-entry valid flags, so no clearing pass is needed. Taps are not cleared.
// ----------------------------------------------------------------------------
module complex_decimating_fir #(
  parameter int MAX_TAPS  = 64,
  parameter int NUM_FREQS = 4
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  cdf_pkg::reg_idx_t         cfg_index,
  input  logic [cdf_pkg::CFG_W-1:0] cfg_data,
  cdf_in_if.sink                    din,
  cdf_out_if.source                 dout
);
  import cdf_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  cdf_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (din.valid),
    .in_command (din.command),
    .in_ready   (din.ready),
    .status     (status),
    .cmd        (cmd)
  );

  cdf_datapath #(
    .MAX_TAPS  (MAX_TAPS),
    .NUM_FREQS (NUM_FREQS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .status     (status),
    .sample_re  (din.sample_re),
    .sample_im  (din.sample_im),
    .tap_freq   (din.tap_freq),
    .tap_index  (din.tap_index),
    .tap_re     (din.tap_re),
    .tap_im     (din.tap_im),
    .out_ready  (dout.ready),
    .out_valid  (dout.valid),
    .freq_index (dout.freq_index),
    .out_re     (dout.out_re),
    .out_im     (dout.out_im),
    .out_last   (dout.last)
  );

endmodule

@@ tb/sv/cdf_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdf_checker
// Watches the config port and both channels of the complex decimating FIR.
// Tracks its own copy of the ring, taps, position, group count and settings.
// It applies every accepted input transaction; for a push that closes a group
// it computes the filter bank results and queues them. Each output transaction
// is checked field by field against the oldest queued result.
// ----------------------------------------------------------------------------
module cdf_checker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  cdf_pkg::reg_idx_t         cfg_index,
  input  logic [cdf_pkg::CFG_W-1:0] cfg_data,
  cdf_in_if                         din,
  cdf_out_if                        dout,
  output int                        outstanding,
  output int                        mismatches
);
  import cdf_pkg::*;

  localparam int RING_DEPTH = 64;
  localparam int FREQ_COUNT = 4;

  typedef struct packed {
    logic [1:0] freq;
    sample_t    re;
    sample_t    im;
    logic       last;
  } fir_result_t;

  sample_t                ring_re [RING_DEPTH];
  sample_t                ring_im [RING_DEPTH];
  tap_t                   coef_re [FREQ_COUNT][RING_DEPTH];
  tap_t                   coef_im [FREQ_COUNT][RING_DEPTH];
  int unsigned            wr_pos;
  logic [GC_W-1:0]        group_cnt;
  logic [CFG_W-1:0]       dec_reg;
  logic [FREQS_CFG_W-1:0] freqs_reg;
  fir_result_t            expected_results [$];
  int                     errs = 0;

  assign mismatches = errs;

  function automatic sample_t scale_saturate(input longint acc);
    longint q;
    q = acc / (longint'(1) <<< SCALE_SHIFT);
    if (q > 32767) q = 32767;
    else if (q < -32768) q = -32768;
    return sample_t'(q);
  endfunction

  task automatic filter_transaction(input logic [1:0] cmd, input sample_t s_re,
                                    input sample_t s_im, input logic [1:0] t_f,
                                    input logic [5:0] t_k, input tap_t t_re,
                                    input tap_t t_im);
    int unsigned d;
    int unsigned len;
    int unsigned nf;
    int unsigned idx;
    longint      acc_re;
    longint      acc_im;
    fir_result_t r;
    case (cmd)
      CMD_LOAD: begin
        coef_re[t_f][t_k] = t_re;
        coef_im[t_f][t_k] = t_im;
      end
      CMD_CLEAR: begin
        for (int i = 0; i < RING_DEPTH; i++) begin
          ring_re[i] = '0;
          ring_im[i] = '0;
        end
      end
      CMD_PUSH: begin
        d = (dec_reg == 0) ? 1 : (dec_reg > RING_DEPTH / 2) ? RING_DEPTH / 2 : dec_reg;
        len = 2 * d;
        if (wr_pos >= len) wr_pos = 0;
        ring_re[wr_pos] = s_re;
        ring_im[wr_pos] = s_im;
        wr_pos = (wr_pos + 1 == len) ? 0 : wr_pos + 1;
        group_cnt = group_cnt + 1'b1;
        if (group_cnt == 0 || group_cnt >= d) begin
          group_cnt = '0;
          nf = (freqs_reg == 0) ? 1 : (freqs_reg > FREQ_COUNT) ? FREQ_COUNT : freqs_reg;
          for (int f = 0; f < nf; f++) begin
            acc_re = 0;
            acc_im = 0;
            idx = wr_pos;
            for (int k = 0; k < len; k++) begin
              acc_re += longint'(coef_re[f][k]) * ring_re[idx]
                      - longint'(coef_im[f][k]) * ring_im[idx];
              acc_im += longint'(coef_re[f][k]) * ring_im[idx]
                      + longint'(coef_im[f][k]) * ring_re[idx];
              idx = (idx + 1 == len) ? 0 : idx + 1;
            end
            r.freq = 2'(f);
            r.re   = scale_saturate(acc_re);
            r.im   = scale_saturate(acc_im);
            r.last = (f + 1 == nf);
            expected_results = {expected_results, r};
          end
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin : monitor
    fir_result_t got;
    fir_result_t want;
    if (rst) begin
      for (int i = 0; i < RING_DEPTH; i++) begin
        ring_re[i] = '0;
        ring_im[i] = '0;
      end
      wr_pos    = 0;
      group_cnt = '0;
      dec_reg   = DEC_RESET;
      freqs_reg = FREQS_RESET;
      expected_results.delete();
    end else begin
      if (dout.valid && dout.ready) begin
        got = '{dout.freq_index, dout.out_re, dout.out_im, dout.last};
        if (expected_results.size() == 0) begin
          errs++;
          $display("%0t: unexpected result freq=%0d re=%0d im=%0d last=%0b",
                   $time, got.freq, got.re, got.im, got.last);
        end else begin
          want = expected_results.pop_front();
          if (got.freq !== want.freq || got.re !== want.re || got.im !== want.im ||
              got.last !== want.last) begin
            errs++;
            $display("%0t: expected %0d/%0d/%0d/%0b actual %0d/%0d/%0d/%0b",
                     $time, want.freq, want.re, want.im, want.last,
                     got.freq, got.re, got.im, got.last);
          end
        end
      end
      if (din.valid && din.ready)
        filter_transaction(din.command, din.sample_re, din.sample_im, din.tap_freq,
                           din.tap_index, din.tap_re, din.tap_im);
      if (cfg_we) begin
        case (cfg_index)
          REG_DECIMATION: dec_reg = cfg_data;
          REG_FREQS:      freqs_reg = cfg_data[FREQS_CFG_W-1:0];
          default: ;
        endcase
      end
    end
    outstanding <= expected_results.size();
  end

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the complex decimating FIR filter bank.
// Loads the taps in use, runs a directed set of extreme samples, taps, clears
// and unknown commands, then random traffic over several decimation and
// frequency settings, with random gaps on both channels, a stall-free stretch
// and one long output hold-off. Checking is done by cdf_checker.
// ----------------------------------------------------------------------------
module testbench;
  import cdf_pkg::*;

  localparam logic [1:0] CMD_UNKNOWN = 2'd3;
  localparam sample_t    SMP_MAX     = 16'sh7FFF;
  localparam sample_t    SMP_MIN     = 16'sh8000;
  localparam tap_t       TAP_MAX     = 18'sh1FFFF;
  localparam tap_t       TAP_MIN     = 18'sh20000;
  localparam int         FREQ0_TAPS  = 64;
  localparam int         OTHER_TAPS  = 10;
  localparam int         PHASES      = 8;
  localparam logic [CFG_W-1:0] PHASE_DEC [PHASES] =
    '{6'd1, 6'd0, 6'd3, 6'd8, 6'd32, 6'd63, 6'd5, 6'd2};
  localparam logic [CFG_W-1:0] PHASE_FREQS [PHASES] =
    '{6'd4, 6'd0, 6'd2, 6'd1, 6'd1, 6'd1, 6'd5, 6'd7};
  localparam int PHASE_ITEMS [PHASES] = '{8, 6, 10, 10, 28, 28, 10, 8};

  logic             clk;
  logic             rst;
  logic             cfg_we;
  reg_idx_t         cfg_index;
  logic [CFG_W-1:0] cfg_data;
  int               outstanding;
  int               mismatches;
  bit               steady;
  bit               hold_req;

  cdf_in_if  din_ch ();
  cdf_out_if dout_ch ();

  complex_decimating_fir u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .din       (din_ch),
    .dout      (dout_ch)
  );

  cdf_checker u_chk (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .din         (din_ch),
    .dout        (dout_ch),
    .outstanding (outstanding),
    .mismatches  (mismatches)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin : receiver
    int hold_left;
    hold_left = 0;
    dout_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        dout_ch.ready <= 1'b0;
      end else begin
        dout_ch.ready <= steady || ($urandom_range(0, 99) >= 34);
      end
    end
  end

  function automatic sample_t pick_sample();
    case ($urandom_range(0, 7))
      0: return SMP_MAX;
      1: return SMP_MIN;
      2: return '0;
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic tap_t pick_tap();
    case ($urandom_range(0, 7))
      0: return TAP_MAX;
      1: return TAP_MIN;
      2: return '0;
      default: return tap_t'($urandom);
    endcase
  endfunction

  task automatic send_item(input logic [1:0] cmd, input sample_t s_re, input sample_t s_im,
                           input logic [1:0] t_f, input logic [5:0] t_k, input tap_t t_re,
                           input tap_t t_im);
    while (!steady && $urandom_range(0, 99) < 34) begin
      din_ch.valid <= 1'b0;
      @(posedge clk);
    end
    din_ch.valid     <= 1'b1;
    din_ch.command   <= cmd;
    din_ch.sample_re <= s_re;
    din_ch.sample_im <= s_im;
    din_ch.tap_freq  <= t_f;
    din_ch.tap_index <= t_k;
    din_ch.tap_re    <= t_re;
    din_ch.tap_im    <= t_im;
    do @(posedge clk); while (!din_ch.ready);
  endtask

  task automatic push_sample(input sample_t s_re, input sample_t s_im);
    send_item(CMD_PUSH, s_re, s_im, 2'($urandom), 6'($urandom), pick_tap(), pick_tap());
  endtask

  task automatic load_tap(input logic [1:0] t_f, input logic [5:0] t_k, input tap_t t_re,
                          input tap_t t_im);
    send_item(CMD_LOAD, pick_sample(), pick_sample(), t_f, t_k, t_re, t_im);
  endtask

  task automatic random_item();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75)
      push_sample(pick_sample(), pick_sample());
    else if (r < 88)
      load_tap(2'($urandom), 6'($urandom), pick_tap(), pick_tap());
    else if (r < 94)
      send_item(CMD_CLEAR, pick_sample(), pick_sample(), 2'($urandom), 6'($urandom),
                pick_tap(), pick_tap());
    else
      send_item(CMD_UNKNOWN, pick_sample(), pick_sample(), 2'($urandom), 6'($urandom),
                pick_tap(), pick_tap());
  endtask

  task automatic drain();
    din_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_settings(input logic [CFG_W-1:0] dec, input logic [CFG_W-1:0] nf);
    cfg_we    <= 1'b1;
    cfg_index <= REG_DECIMATION;
    cfg_data  <= dec;
    @(posedge clk);
    cfg_index <= REG_FREQS;
    cfg_data  <= nf;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin : stimulus
    int n;
    steady   = 1'b0;
    hold_req = 1'b0;
    rst              <= 1'b1;
    cfg_we           <= 1'b0;
    cfg_index        <= REG_DECIMATION;
    cfg_data         <= '0;
    din_ch.valid     <= 1'b0;
    din_ch.command   <= CMD_PUSH;
    din_ch.sample_re <= '0;
    din_ch.sample_im <= '0;
    din_ch.tap_freq  <= '0;
    din_ch.tap_index <= '0;
    din_ch.tap_re    <= '0;
    din_ch.tap_im    <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // frequencies above 0 only run with decimation up to 5
    for (int f = 0; f < 4; f++)
      for (int k = 0; k < ((f == 0) ? FREQ0_TAPS : OTHER_TAPS); k++)
        load_tap(2'(f), 6'(k), pick_tap(), pick_tap());
    drain();

    write_settings(6'd1, 6'd4);
    load_tap(2'd0, 6'd0, TAP_MIN, TAP_MIN);
    load_tap(2'd0, 6'd1, TAP_MAX, TAP_MAX);
    load_tap(2'd1, 6'd0, TAP_MAX, TAP_MIN);
    load_tap(2'd1, 6'd1, TAP_MIN, TAP_MAX);
    push_sample(SMP_MAX, SMP_MAX);
    push_sample(SMP_MIN, SMP_MIN);
    push_sample(SMP_MIN, SMP_MAX);
    push_sample(SMP_MAX, SMP_MIN);
    push_sample('0, '0);
    send_item(CMD_CLEAR, pick_sample(), pick_sample(), 2'($urandom), 6'($urandom),
              pick_tap(), pick_tap());
    push_sample(16'sd1, -16'sd1);
    send_item(CMD_UNKNOWN, pick_sample(), pick_sample(), 2'($urandom), 6'($urandom),
              pick_tap(), pick_tap());
    push_sample(-16'sd1, 16'sd1);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      write_settings(PHASE_DEC[p], PHASE_FREQS[p]);
      steady = (p == 4);
      if (p == 0) hold_req = 1'b1;
      n = PHASE_ITEMS[p] + $urandom_range(0, 3);
      repeat (n) random_item();
      drain();
    end
    steady = 1'b0;

    repeat (300) @(posedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
